[src/scit_pkg.sv]
`timescale 1ns / 1ps

package scit_pkg;

	localparam int NUM_SECTORS = 256;
	localparam int IDX_W       = $clog2(NUM_SECTORS);
	localparam int CNT_W       = $clog2(NUM_SECTORS + 1);

	localparam int CMD_W    = 2;
	localparam int SECTOR_W = 8;
	localparam int ID_W     = 32;

	typedef logic [CMD_W-1:0] cmd_code_t;

	localparam cmd_code_t CMD_SET   = 2'd0;
	localparam cmd_code_t CMD_QUERY = 2'd1;
	localparam cmd_code_t CMD_INIT  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic execute;
	} dp_ctl_t;

endpackage

[src/scit_ctrl.sv]
`timescale 1ns / 1ps

module scit_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output scit_pkg::dp_ctl_t ctl
);
	import scit_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		in_stall    = (state_q != ST_IDLE);
		ctl.capture = in_valid && (state_q == ST_IDLE);
		ctl.execute = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
					if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					if (!out_valid_q || !out_stall) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[src/scit_dp.sv]
`timescale 1ns / 1ps

module scit_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scit_pkg::dp_ctl_t             ctl,
	input  logic                          cfg_we,
	input  logic [scit_pkg::ID_W-1:0]     cfg_wdata,
	input  logic [scit_pkg::CMD_W-1:0]    command,
	input  logic [scit_pkg::SECTOR_W-1:0] sector,
	input  logic [scit_pkg::ID_W-1:0]     change_id,
	output logic [scit_pkg::ID_W-1:0]     sector_id,
	output logic                          cleared,
	output logic                          all_done,
	output logic                          bad_sector
);
	import scit_pkg::*;

	// captured request
	cmd_code_t             op_cmd_q;
	logic [SECTOR_W-1:0]   op_sector_q;
	logic [ID_W-1:0]       op_id_q;

	// tracker state
	logic [ID_W-1:0]        min_id_q;
	logic [ID_W-1:0]        cur_id_q;
	logic [NUM_SECTORS-1:0] pend_q;
	logic [CNT_W-1:0]       pend_cnt_q;

	// result register
	logic [ID_W-1:0] sector_id_q;
	logic            cleared_q;
	logic            all_done_q;
	logic            bad_q;

	logic [31:0]            sec_ext;
	logic                   in_range;
	logic [IDX_W-1:0]       idx;
	logic [ID_W-1:0]        cur_id_d;
	logic [NUM_SECTORS-1:0] pend_d;
	logic [CNT_W-1:0]       pend_cnt_d;
	logic [ID_W-1:0]        ans_d;
	logic                   clr_d;
	logic                   done_d;
	logic                   bad_d;

	assign sec_ext  = 32'(op_sector_q);
	assign in_range = (sec_ext < 32'(NUM_SECTORS));
	assign idx      = sec_ext[IDX_W-1:0];

	always_comb begin
		cur_id_d   = cur_id_q;
		pend_d     = pend_q;
		pend_cnt_d = pend_cnt_q;
		ans_d      = '0;
		clr_d      = 1'b0;
		done_d     = 1'b0;
		bad_d      = 1'b0;
		case (op_cmd_q)
			CMD_SET: begin
				if (!in_range) begin
					bad_d = 1'b1;
				end else if (op_id_q > cur_id_q) begin
					// adopt newer id: everything pending except this sector
					cur_id_d    = op_id_q;
					pend_d      = '1;
					pend_d[idx] = 1'b0;
					pend_cnt_d  = CNT_W'(NUM_SECTORS - 1);
					clr_d       = 1'b1;
					done_d      = (CNT_W'(NUM_SECTORS - 1) == '0);
				end else if (op_id_q == cur_id_q && pend_q[idx]) begin
					pend_d[idx] = 1'b0;
					pend_cnt_d  = pend_cnt_q - CNT_W'(1);
					clr_d       = 1'b1;
					done_d      = (pend_cnt_q == CNT_W'(1));
				end
			end
			CMD_QUERY: begin
				if (!in_range) begin
					bad_d = 1'b1;
				end else begin
					ans_d = pend_q[idx] ? '0 : cur_id_q;
				end
			end
			CMD_INIT: begin
				if (cur_id_q <= min_id_q) begin
					cur_id_d   = min_id_q;
					pend_d     = '0;
					pend_cnt_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			op_cmd_q    <= command;
			op_sector_q <= sector;
			op_id_q     <= change_id;
		end
		if (ctl.execute) begin
			sector_id_q <= ans_d;
			cleared_q   <= clr_d;
			all_done_q  <= done_d;
			bad_q       <= bad_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_id_q   <= '0;
			cur_id_q   <= '0;
			pend_q     <= '0;
			pend_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				min_id_q <= cfg_wdata;
			end
			if (ctl.execute) begin
				cur_id_q   <= cur_id_d;
				pend_q     <= pend_d;
				pend_cnt_q <= pend_cnt_d;
			end
		end
	end

	assign sector_id  = sector_id_q;
	assign cleared    = cleared_q;
	assign all_done   = all_done_q;
	assign bad_sector = bad_q;

endmodule

[src/sector_change_id_tracker.sv]
// flow: an accepted request is captured in the request register, then executed
//   into the output register once it is free; its result is valid from then on
// one request at a time: the request register is free again, and a new request
//   taken, as soon as execution moves the result into the output register
// reset: arst_n clears the current id, the min id register, all pending bits
//   and the pending count at once; there is no clearing pass
`timescale 1ns / 1ps

module sector_change_id_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	// min change id register
	input  logic                          cfg_we,
	input  logic [scit_pkg::ID_W-1:0]     cfg_wdata,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [scit_pkg::CMD_W-1:0]    command,
	input  logic [scit_pkg::SECTOR_W-1:0] sector,
	input  logic [scit_pkg::ID_W-1:0]     change_id,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [scit_pkg::ID_W-1:0]     sector_id,
	output logic                          cleared,
	output logic                          all_done,
	output logic                          bad_sector
);
	import scit_pkg::*;

	// capture / execute strobes from the sequencer
	dp_ctl_t ctl;

	// sequencer: idle takes a request, exec waits for a free output register
	scit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl)
	);

	// datapath: flop pending bitmap, pending count, current id, result register
	scit_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.command    (command),
		.sector     (sector),
		.change_id  (change_id),
		.sector_id  (sector_id),
		.cleared    (cleared),
		.all_done   (all_done),
		.bad_sector (bad_sector)
	);

endmodule

[src/scit_chk.sv]
`timescale 1ns / 1ps

module scit_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [scit_pkg::ID_W-1:0]     sector_id,
	input logic                          cleared,
	input logic                          all_done,
	input logic                          bad_sector
);
	import scit_pkg::*;

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// one request in flight: the request side closes right after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request accepted while one in flight");

	a_done_needs_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && all_done |-> cleared)
		else $error("all_done without cleared");

	a_bad_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_sector |-> !cleared && !all_done && sector_id == '0)
		else $error("bad sector result carries data");

	a_clear_no_answer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cleared |-> sector_id == '0)
		else $error("set result carries an answer");

endmodule

bind sector_change_id_tracker scit_chk u_scit_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.sector_id  (sector_id),
	.cleared    (cleared),
	.all_done   (all_done),
	.bad_sector (bad_sector)
);

[sim/sector_tracker_checker.sv]
`timescale 1ns / 1ps

module sector_tracker_checker
	import scit_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [ID_W-1:0]     cfg_wdata,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [CMD_W-1:0]    command,
	input  logic [SECTOR_W-1:0] sector,
	input  logic [ID_W-1:0]     change_id,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [ID_W-1:0]     sector_id,
	input  logic                cleared,
	input  logic                all_done,
	input  logic                bad_sector,
	output int                  mismatch_count,
	output int                  results_due
);

	typedef struct packed {
		logic [ID_W-1:0] sector_id;
		logic            cleared;
		logic            all_done;
		logic            bad_sector;
	} sector_result_t;

	logic [ID_W-1:0]        live_id   = '0;
	logic [ID_W-1:0]        floor_id  = '0;
	logic [NUM_SECTORS-1:0] dirty_map = '0;
	int unsigned            dirty_cnt = 0;
	sector_result_t         owed_results[$];
	int                     err_cnt = 0;
	int                     due_cnt = 0;

	assign mismatch_count = err_cnt;
	assign results_due    = due_cnt;

	// sector id tracking, one result per request
	task automatic track_request(input cmd_code_t cmd, input logic [SECTOR_W-1:0] sec,
		input logic [ID_W-1:0] id, output sector_result_t res);
		res = '0;
		case (cmd)
			CMD_SET, CMD_QUERY: begin
				if (int'(sec) >= NUM_SECTORS) begin
					res.bad_sector = 1'b1;
				end else if (cmd == CMD_SET) begin
					if (id > live_id) begin
						live_id   = id;
						dirty_map = '1;
						dirty_cnt = NUM_SECTORS;
					end
					if (id == live_id && dirty_map[sec]) begin
						dirty_map[sec] = 1'b0;
						dirty_cnt--;
						res.cleared  = 1'b1;
						res.all_done = (dirty_cnt == 0);
					end
				end else begin
					res.sector_id = dirty_map[sec] ? '0 : live_id;
				end
			end
			CMD_INIT: begin
				if (live_id <= floor_id) begin
					live_id   = floor_id;
					dirty_map = '0;
					dirty_cnt = 0;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		sector_result_t want;
		if (!arst_n) begin
			live_id   = '0;
			floor_id  = '0;
			dirty_map = '0;
			dirty_cnt = 0;
			owed_results.delete();
		end else begin
			if (cfg_we)
				floor_id = cfg_wdata;
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					$error("result with nothing owed: sector_id %h cleared %b all_done %b bad %b",
						sector_id, cleared, all_done, bad_sector);
					err_cnt++;
				end else begin
					want = owed_results.pop_front();
					if (sector_id !== want.sector_id) begin
						$error("sector_id: expected %h, got %h", want.sector_id, sector_id);
						err_cnt++;
					end
					if (cleared !== want.cleared) begin
						$error("cleared: expected %b, got %b", want.cleared, cleared);
						err_cnt++;
					end
					if (all_done !== want.all_done) begin
						$error("all_done: expected %b, got %b", want.all_done, all_done);
						err_cnt++;
					end
					if (bad_sector !== want.bad_sector) begin
						$error("bad_sector: expected %b, got %b", want.bad_sector, bad_sector);
						err_cnt++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				track_request(cmd_code_t'(command), sector, change_id, want);
				owed_results.push_back(want);
			end
		end
		due_cnt = owed_results.size();
	end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import scit_pkg::*;

	// command code the block leaves unused
	localparam cmd_code_t CMD_UNUSED = 2'd3;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 200;  // long output hold-off, fills the block
	localparam int DRAIN_CYCLES = 6;    // margin past the result latency
	localparam int ROUND_TARGET = 1750; // requests before the closing phase
	localparam int ZERO_MIN_AT  = 900;  // switch the min id register to zero here

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [ID_W-1:0]     cfg_wdata;
	logic                in_valid;
	logic                in_stall;
	logic [CMD_W-1:0]    command;
	logic [SECTOR_W-1:0] sector;
	logic [ID_W-1:0]     change_id;
	logic                out_valid;
	logic                out_stall;
	logic [ID_W-1:0]     sector_id;
	logic                cleared;
	logic                all_done;
	logic                bad_sector;

	int mismatch_count;
	int results_due;
	int cycle_count = 0;

	// stimulus side bookkeeping: highest id the block should hold, and the min register
	logic [ID_W-1:0] id_hint = '0;
	logic [ID_W-1:0] min_now = '0;
	int              sent_count = 0;
	int              sender_idle_pct = 0;
	int              sink_idle_pct = 0;
	bit              hold_off_req = 1'b0;

	sector_change_id_tracker i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.sector     (sector),
		.change_id  (change_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sector_id  (sector_id),
		.cleared    (cleared),
		.all_done   (all_done),
		.bad_sector (bad_sector)
	);

	sector_tracker_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.sector         (sector),
		.change_id      (change_id),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.sector_id      (sector_id),
		.cleared        (cleared),
		.all_done       (all_done),
		.bad_sector     (bad_sector),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("testbench: done, errors");
		$finish;
	end

	// result side: random stall bursts, plus one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
				out_stall    = 1'b0;
			end else if (sink_idle_pct != 0 && $urandom_range(1, 100) <= sink_idle_pct) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	// offer one request, entered and left at a falling edge
	task automatic send_request(input cmd_code_t cmd, input logic [SECTOR_W-1:0] sec,
		input logic [ID_W-1:0] id);
		// optional gap in front of the request
		if (sender_idle_pct != 0 && $urandom_range(1, 100) <= sender_idle_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid  = 1'b1;
		command   = cmd;
		sector    = sec;
		change_id = id;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		// a following request raises valid again in this same step
		in_valid = 1'b0;
		sent_count++;
		// the block's id only ever moves up, through a higher set or an init
		if (cmd == CMD_SET && id > id_hint)
			id_hint = id;
		if (cmd == CMD_INIT && id_hint <= min_now)
			id_hint = min_now;
	endtask

	// hold off until every owed result has come back
	task automatic wait_drained();
		do @(negedge clk); while (results_due != 0);
	endtask

	// register writes only with the block idle
	task automatic write_min_id(input logic [ID_W-1:0] value);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we  = 1'b0;
		min_now = value;
	endtask

	// stray traffic mixed into a round: queries, stale sets, repeats, inits, junk
	task automatic send_noise();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			send_request(CMD_QUERY, SECTOR_W'($urandom), $urandom);
		else if (pick < 70)
			send_request(CMD_SET, SECTOR_W'($urandom), id_hint - $urandom_range(1, 5000));
		else if (pick < 85)
			send_request(CMD_SET, SECTOR_W'($urandom), id_hint);
		else if (pick < 95)
			send_request(CMD_INIT, SECTOR_W'($urandom), $urandom);
		else
			send_request(CMD_UNUSED, SECTOR_W'($urandom), $urandom);
	endtask

	// one update round: a higher id marks every sector pending, then each sector
	// reports the same id in shuffled order; a broken round stops part way
	task automatic run_round(input bit complete);
		logic [SECTOR_W-1:0] visit [NUM_SECTORS];
		logic [SECTOR_W-1:0] tmp;
		logic [ID_W-1:0]     round_id;
		int                  swap_at;
		int                  stop_at;
		round_id = id_hint + $urandom_range(1, 4096);
		for (int i = 0; i < NUM_SECTORS; i++)
			visit[i] = SECTOR_W'(i);
		for (int i = NUM_SECTORS - 1; i > 0; i--) begin
			swap_at        = $urandom_range(0, i);
			tmp            = visit[i];
			visit[i]       = visit[swap_at];
			visit[swap_at] = tmp;
		end
		stop_at = complete ? NUM_SECTORS : $urandom_range(10, NUM_SECTORS - 10);
		for (int i = 0; i < stop_at; i++) begin
			while ($urandom_range(0, 3) == 0)
				send_noise();
			send_request(CMD_SET, visit[i], round_id);
		end
	endtask

	function automatic int pick_idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 35;
		endcase
	endfunction

	initial begin
		bit min_zeroed;
		bit first_round;
		min_zeroed  = 1'b0;
		first_round = 1'b1;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		command   = CMD_SET;
		sector    = '0;
		change_id = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, small min id
		write_min_id(32'd5);
		send_request(CMD_QUERY, 8'd0, 32'hFFFF_FFFF);    // fresh block, nothing pending
		send_request(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF);  // unused command, all zero
		send_request(CMD_SET, 8'd0, 32'd0);              // equal id, sector not pending
		send_request(CMD_INIT, 8'hFF, 32'd0);            // current below min: forced up
		send_request(CMD_QUERY, 8'hFF, 32'd0);
		send_request(CMD_SET, 8'd0, 32'd3);              // lower id, ignored
		send_request(CMD_SET, 8'd0, 32'd5);              // equal, not pending
		send_request(CMD_SET, 8'd7, 32'd9);              // higher: adopt and clear own bit
		send_request(CMD_SET, 8'd7, 32'd9);              // already cleared
		send_request(CMD_QUERY, 8'd7, 32'd0);
		send_request(CMD_QUERY, 8'd8, 32'd0);            // pending answers zero
		send_request(CMD_INIT, 8'hFF, 32'hFFFF_FFFF);    // current above min: no change
		send_request(CMD_QUERY, 8'd8, 32'd0);
		send_request(CMD_SET, 8'hFF, 32'd9);
		send_request(CMD_SET, 8'd0, 32'd9);
		send_request(CMD_SET, 8'd100, 32'd8);
		send_request(CMD_QUERY, 8'd100, 32'd0);
		send_request(CMD_UNUSED, 8'd0, 32'd0);

		// rounds on a mid-range min id, later on a zero min id
		write_min_id($urandom_range(10000, 100000));
		send_request(CMD_INIT, 8'd0, 32'd0);
		while (sent_count < ROUND_TARGET) begin
			if (!min_zeroed && sent_count > ZERO_MIN_AT) begin
				write_min_id('0);
				send_request(CMD_INIT, 8'd0, 32'd0);
				min_zeroed = 1'b1;
			end
			sender_idle_pct = pick_idle_pct();
			sink_idle_pct   = pick_idle_pct();
			// the first round starts under a long output hold-off
			if (first_round)
				hold_off_req = 1'b1;
			run_round($urandom_range(0, 2) != 0);
			if (first_round || $urandom_range(0, 2) == 0)
				wait_drained();
			first_round = 1'b0;
		end

		// closing phase, no idling: min id at its top value, fully random requests
		sender_idle_pct = 0;
		sink_idle_pct   = 0;
		write_min_id('1);
		send_request(CMD_INIT, 8'd0, 32'd0);
		send_request(CMD_SET, 8'hFF, 32'hFFFF_FFFF);
		send_request(CMD_QUERY, 8'hFF, 32'd0);
		repeat (150)
			send_request(cmd_code_t'($urandom_range(0, 3)), SECTOR_W'($urandom), $urandom);

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
